// ===== sv/bond_angle_dihedral_classifier_unit_assert.svh =====
// Assertion macros shared by the checker of the bead geometry classifier.
`ifndef BOND_ANGLE_DIHEDRAL_CLASSIFIER_UNIT_ASSERT_SVH
`define BOND_ANGLE_DIHEDRAL_CLASSIFIER_UNIT_ASSERT_SVH
// Next-cycle implication, switched off while reset is high.
`define BADC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier port check failed");
// Next-cycle implication that also watches the reset cycles.
`define BADC_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("classifier reset check failed");
`endif

// ===== sv/badc_pkg.sv =====
// Shared types, codes and the micro-program of the bead geometry classifier.
`default_nettype none
package badc_pkg;

  localparam int BEAD_DEPTH = 4096;
  localparam int BEAD_AW    = $clog2(BEAD_DEPTH);
  localparam int IDX_W      = 12;
  localparam int POS_W      = 32;
  localparam int CUT_W      = 31;
  localparam int COS_W      = 32;
  localparam int COMP_W     = 34;
  localparam int PROD_W     = 2 * COMP_W;
  localparam int FQ_DEPTH   = 2;
  localparam int NORM_MAX   = 32767;

  typedef logic [1:0] op_t;
  localparam op_t OP_STORE = 2'd0;
  localparam op_t OP_BOND  = 2'd1;
  localparam op_t OP_ANGLE = 2'd2;
  localparam op_t OP_DIHED = 2'd3;

  typedef logic [2:0] class_t;
  localparam class_t CL_SHORT     = 3'd0;
  localparam class_t CL_LONG      = 3'd1;
  localparam class_t CL_HELIX     = 3'd2;
  localparam class_t CL_COIL      = 3'd3;
  localparam class_t CL_EXTENDED  = 3'd4;
  localparam class_t CL_DIH_HELIX = 3'd5;
  localparam class_t CL_DIH_EXT   = 3'd6;
  localparam class_t CL_STORED    = 3'd7;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_BOND_CUT    = 2'd0;
  localparam cfg_idx_t CFG_ANGLE_HELIX = 2'd1;
  localparam cfg_idx_t CFG_ANGLE_COIL  = 2'd2;
  localparam cfg_idx_t CFG_DIHED_HELIX = 2'd3;

  localparam logic [CUT_W-1:0] RST_BOND_CUT    = 31'd209715;
  localparam logic [COS_W-1:0] RST_ANGLE_HELIX = 32'hE55DD9D0;
  localparam logic [COS_W-1:0] RST_ANGLE_COIL  = 32'hD55BBBE9;
  localparam logic [COS_W-1:0] RST_DIHED_HELIX = 32'hE55DD9D0;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic [2:0][COMP_W-1:0] vec_t;
  localparam comp_t ONE_Q30 = 34'sd1073741824;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;
    logic [POS_W-1:0] pz;
    logic [2:0]       nrd;
  } item_t;

  typedef enum logic [2:0] {
    BS_IDLE, BS_READ, BS_DIFF, BS_EXEC, BS_SQRT, BS_DONE
  } back_state_t;

  typedef enum logic [3:0] {
    UK_BOND_CHK, UK_BOND_CMP, UK_AZERO, UK_DZERO, UK_SIGN,
    UK_NORM, UK_DOT, UK_CROSS, UK_ROOT, UK_THR
  } uop_kind_t;

  typedef enum logic [2:0] {VI_U, VI_V, VI_W, VI_P, VI_Q} vec_id_t;
  typedef enum logic [1:0] {DD_ACC, DD_XX, DD_YY, DD_XY} dot_dst_t;
  typedef enum logic [1:0] {TS_ANGLE_HELIX, TS_ANGLE_COIL, TS_DIHED_HELIX} thr_sel_t;

  typedef struct packed {
    uop_kind_t kind;
    vec_id_t   x;
    vec_id_t   y;
    vec_id_t   vd;
    dot_dst_t  dd;
    thr_sel_t  ts;
    class_t    hit;
    class_t    miss;
    logic      cont;
  } uop_t;

  function automatic comp_t psub(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    return $signed({{2{a[POS_W-1]}}, a}) - $signed({{2{b[POS_W-1]}}, b});
  endfunction

  function automatic vec_t vdiff(logic [3*POS_W-1:0] a, logic [3*POS_W-1:0] b);
    vec_t v;
    v[0] = psub(a[POS_W-1:0], b[POS_W-1:0]);
    v[1] = psub(a[2*POS_W-1:POS_W], b[2*POS_W-1:POS_W]);
    v[2] = psub(a[3*POS_W-1:2*POS_W], b[3*POS_W-1:2*POS_W]);
    return v;
  endfunction

  function automatic comp_t cpick(vec_t v, logic [1:0] i);
    comp_t r;
    r = '0;
    if (i != 2'd3) r = $signed(v[i]);
    return r;
  endfunction

  function automatic logic [COMP_W-1:0] cmag(comp_t c);
    return c[COMP_W-1] ? -c : c;
  endfunction

  // The step list of each classify operation; each step is one micro-op.
  function automatic uop_t badc_prog(op_t op, logic [3:0] stp);
    uop_t u;
    u.kind = UK_THR;
    u.x    = VI_U;
    u.y    = VI_U;
    u.vd   = VI_U;
    u.dd   = DD_ACC;
    u.ts   = TS_ANGLE_HELIX;
    u.hit  = CL_LONG;
    u.miss = CL_LONG;
    u.cont = 1'b0;
    case (op)
      OP_BOND: begin
        case (stp)
          4'd0:    u.kind = UK_BOND_CHK;
          4'd1:    u.kind = UK_DOT;
          default: u.kind = UK_BOND_CMP;
        endcase
      end
      OP_ANGLE: begin
        case (stp)
          4'd0: u.kind = UK_AZERO;
          4'd1: begin u.kind = UK_NORM; u.x = VI_U; end
          4'd2: begin u.kind = UK_NORM; u.x = VI_V; end
          4'd3: begin u.kind = UK_DOT; u.x = VI_U; u.y = VI_U; u.dd = DD_XX; end
          4'd4: begin u.kind = UK_DOT; u.x = VI_V; u.y = VI_V; u.dd = DD_YY; end
          4'd5: begin u.kind = UK_DOT; u.x = VI_U; u.y = VI_V; u.dd = DD_XY; end
          4'd6: u.kind = UK_ROOT;
          4'd7: begin
            u.ts = TS_ANGLE_HELIX; u.hit = CL_HELIX; u.cont = 1'b1;
          end
          default: begin
            u.ts = TS_ANGLE_COIL; u.hit = CL_COIL; u.miss = CL_EXTENDED;
          end
        endcase
      end
      default: begin
        case (stp)
          4'd0:  begin u.kind = UK_NORM; u.x = VI_U; end
          4'd1:  begin u.kind = UK_NORM; u.x = VI_V; end
          4'd2:  begin u.kind = UK_NORM; u.x = VI_W; end
          4'd3:  begin u.kind = UK_CROSS; u.x = VI_U; u.y = VI_V; u.vd = VI_P; end
          4'd4:  begin u.kind = UK_CROSS; u.x = VI_W; u.y = VI_V; u.vd = VI_Q; end
          4'd5:  u.kind = UK_DZERO;
          4'd6:  begin u.kind = UK_DOT; u.x = VI_P; u.y = VI_W; end
          4'd7:  u.kind = UK_SIGN;
          4'd8:  begin u.kind = UK_NORM; u.x = VI_P; end
          4'd9:  begin u.kind = UK_NORM; u.x = VI_Q; end
          4'd10: begin u.kind = UK_DOT; u.x = VI_P; u.y = VI_P; u.dd = DD_XX; end
          4'd11: begin u.kind = UK_DOT; u.x = VI_Q; u.y = VI_Q; u.dd = DD_YY; end
          4'd12: begin u.kind = UK_DOT; u.x = VI_P; u.y = VI_Q; u.dd = DD_XY; end
          4'd13: u.kind = UK_ROOT;
          default: begin
            u.ts = TS_DIHED_HELIX; u.hit = CL_DIH_HELIX; u.miss = CL_DIH_EXT;
          end
        endcase
      end
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// ===== sv/badc_isqrt.sv =====
// Iterative floor square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module badc_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic [63:0] n;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic        busy;
  logic [63:0] trial;

  assign trial = r + bitv;
  assign root  = r[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == 5'd31)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n    <= radicand;
      r    <= '0;
      bitv <= 64'h4000_0000_0000_0000;
      cnt  <= '0;
    end else if (busy) begin
      if (n >= trial) begin
        n <= n - trial;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
      bitv <= bitv >> 2;
      cnt  <= cnt + 5'd1;
    end
  end
endmodule
`default_nettype wire

// ===== sv/badc_front.sv =====
// Front end: a two-word input queue that also decodes how many beads an item reads.
`default_nettype none
module badc_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [1:0]               operation,
  input  logic [11:0]              bead_a,
  input  logic [11:0]              bead_b,
  input  logic [11:0]              bead_c,
  input  logic [11:0]              bead_d,
  input  logic signed [31:0]       pos_x,
  input  logic signed [31:0]       pos_y,
  input  logic signed [31:0]       pos_z,
  output logic                     item_valid,
  output badc_pkg::item_t          item,
  input  logic                     item_take
);
  import badc_pkg::*;

  item_t      slot [FQ_DEPTH];
  item_t      incoming;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;

  always_comb begin
    incoming.op = operation;
    incoming.a  = bead_a;
    incoming.b  = bead_b;
    incoming.c  = bead_c;
    incoming.d  = bead_d;
    incoming.px = pos_x;
    incoming.py = pos_y;
    incoming.pz = pos_z;
    unique case (operation)
      OP_STORE: incoming.nrd = 3'd0;
      OP_BOND:  incoming.nrd = 3'd2;
      OP_ANGLE: incoming.nrd = 3'd3;
      default:  incoming.nrd = 3'd4;
    endcase
  end

  assign full       = (cnt == FQ_DEPTH[1:0]);
  assign do_push    = push && !full;
  assign item_valid = (cnt != 2'd0);
  assign item       = slot[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (do_push) wp <= ~wp;
      if (item_take) rp <= ~rp;
      cnt <= cnt + {1'b0, do_push} - {1'b0, item_take};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wp] <= incoming;
  end
endmodule
`default_nettype wire

// ===== sv/badc_back.sv =====
// Back end: bead memory, configuration registers and the micro-coded geometry datapath.
`default_nettype none
module badc_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  badc_pkg::item_t item,
  output logic            item_take,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [31:0]     wr_data,
  input  logic            pop,
  output logic            empty,
  output logic [2:0]      class_code
);
  import badc_pkg::*;

  back_state_t state, state_next;
  item_t       cur;
  logic [3:0]  stp;
  logic [2:0]  k;
  logic [2:0]  rd_cnt;
  logic [3*POS_W-1:0] mem [BEAD_DEPTH];
  logic [3*POS_W-1:0] mem_q;
  logic [3*POS_W-1:0] pa, pb, pc, pd;
  logic [BEAD_AW-1:0] rd_addr;
  vec_t        vec_u, vec_v, vec_w, vec_p, vec_q;
  logic signed [PROD_W-1:0] acc;
  logic [31:0] xx, yy, root;
  comp_t       xy;
  class_t      code;
  logic        res_valid;
  class_t      res_code;
  logic [CUT_W-1:0] cut_len;
  logic [COS_W-1:0] a_helix, a_coil, d_helix;

  uop_t        uop;
  vec_t        xv, yv, dv, nvec, dnew, vw_val;
  logic        vw_en;
  vec_id_t     vw_id;
  comp_t       ma, mb, tclamp, cval;
  logic signed [PROD_W-1:0] prod, acc_dot, xy_sh;
  logic [COS_W-1:0] thr;
  logic [1:0]  ci, cj, cc;
  logic        first, need_shift, above, adv, fin, res_load, sq_start, sq_done;
  class_t      fin_code;
  logic [31:0] sq_root;
  logic [COMP_W-1:0] m0, m1, m2;

  badc_isqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (prod[63:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign uop   = badc_prog(cur.op, stp);
  assign empty = !res_valid;
  assign class_code = res_code;

  function automatic vec_t nshift(vec_t v);
    vec_t  r;
    comp_t c;
    logic [COMP_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      c = $signed(v[i]);
      m = cmag(c) >> 1;
      r[i] = c[COMP_W-1] ? -m : m;
    end
    return r;
  endfunction

  // Operand vectors picked by the current micro-op.
  always_comb begin
    unique case (uop.x)
      VI_U:    xv = vec_u;
      VI_V:    xv = vec_v;
      VI_W:    xv = vec_w;
      VI_P:    xv = vec_p;
      default: xv = vec_q;
    endcase
    unique case (uop.y)
      VI_U:    yv = vec_u;
      VI_V:    yv = vec_v;
      VI_W:    yv = vec_w;
      VI_P:    yv = vec_p;
      default: yv = vec_q;
    endcase
    unique case (uop.vd)
      VI_U:    dv = vec_u;
      VI_V:    dv = vec_v;
      VI_W:    dv = vec_w;
      VI_P:    dv = vec_p;
      default: dv = vec_q;
    endcase
    unique case (uop.ts)
      TS_ANGLE_HELIX: thr = a_helix;
      TS_ANGLE_COIL:  thr = a_coil;
      default:        thr = d_helix;
    endcase
  end

  always_comb begin
    tclamp = $signed({{2{thr[COS_W-1]}}, thr});
    if (tclamp > ONE_Q30) tclamp = ONE_Q30;
    if (tclamp < -ONE_Q30) tclamp = -ONE_Q30;
  end

  // Cross product: component cc uses (i, j) = (cc+1, cc+2) mod 3.
  always_comb begin
    cc    = k[2:1];
    first = !k[0];
    unique case (cc)
      2'd0:    begin ci = 2'd1; cj = 2'd2; end
      2'd1:    begin ci = 2'd2; cj = 2'd0; end
      default: begin ci = 2'd0; cj = 2'd1; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (uop.kind)
      UK_DOT: begin
        ma = cpick(xv, k[1:0]);
        mb = cpick(yv, k[1:0]);
      end
      UK_CROSS: begin
        ma = first ? cpick(xv, ci) : cpick(xv, cj);
        mb = first ? cpick(yv, cj) : cpick(yv, ci);
      end
      UK_BOND_CMP: begin
        ma = $signed({3'b000, cut_len});
        mb = $signed({3'b000, cut_len});
      end
      UK_ROOT: begin
        ma = $signed({2'b00, xx});
        mb = $signed({2'b00, yy});
      end
      UK_THR: begin
        ma = tclamp;
        mb = $signed({2'b00, root});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign acc_dot = ((k == 3'd0) ? '0 : acc) + prod;
  assign xy_sh   = $signed({{4{xy[COMP_W-1]}}, xy, 30'b0});
  assign above   = xy_sh > prod;
  assign cval    = acc[COMP_W-1:0] - prod[COMP_W-1:0];

  always_comb begin
    dnew     = dv;
    dnew[cc] = cval;
  end

  always_comb begin
    m0         = cmag($signed(xv[0]));
    m1         = cmag($signed(xv[1]));
    m2         = cmag($signed(xv[2]));
    need_shift = (m0 > NORM_MAX[COMP_W-1:0]) || (m1 > NORM_MAX[COMP_W-1:0]) ||
                 (m2 > NORM_MAX[COMP_W-1:0]);
    nvec       = nshift(xv);
  end

  // Completion and early exit of the current micro-op.
  always_comb begin
    adv      = 1'b0;
    fin      = 1'b0;
    fin_code = uop.hit;
    unique case (uop.kind)
      UK_BOND_CHK: begin
        if ((cmag($signed(vec_u[0])) >= {3'b000, cut_len}) ||
            (cmag($signed(vec_u[1])) >= {3'b000, cut_len}) ||
            (cmag($signed(vec_u[2])) >= {3'b000, cut_len})) begin
          fin      = 1'b1;
          fin_code = CL_LONG;
        end else begin
          adv = 1'b1;
        end
      end
      UK_BOND_CMP: begin
        fin      = 1'b1;
        fin_code = (acc >= prod) ? CL_LONG : CL_SHORT;
      end
      UK_AZERO: begin
        if ((vec_u == '0) || (vec_v == '0)) begin
          fin      = 1'b1;
          fin_code = CL_EXTENDED;
        end else begin
          adv = 1'b1;
        end
      end
      UK_DZERO: begin
        if ((vec_p == '0) || (vec_q == '0)) begin
          fin      = 1'b1;
          fin_code = CL_DIH_HELIX;
        end else begin
          adv = 1'b1;
        end
      end
      UK_SIGN: begin
        if (acc < 0) begin
          fin      = 1'b1;
          fin_code = CL_DIH_EXT;
        end else begin
          adv = 1'b1;
        end
      end
      UK_NORM:  adv = !need_shift;
      UK_DOT:   adv = (k == 3'd2);
      UK_CROSS: adv = (k == 3'd5);
      UK_ROOT:  adv = 1'b0;
      default: begin
        if (above) begin
          fin      = 1'b1;
          fin_code = uop.hit;
        end else if (uop.cont) begin
          adv = 1'b1;
        end else begin
          fin      = 1'b1;
          fin_code = uop.miss;
        end
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BS_IDLE: begin
        if (item_valid) state_next = (item.op == OP_STORE) ? BS_DONE : BS_READ;
      end
      BS_READ: if (rd_cnt == cur.nrd) state_next = BS_DIFF;
      BS_DIFF: state_next = BS_EXEC;
      BS_EXEC: begin
        if (fin) state_next = BS_DONE;
        else if (uop.kind == UK_ROOT) state_next = BS_SQRT;
      end
      BS_SQRT: if (sq_done) state_next = BS_EXEC;
      BS_DONE: if (!res_valid || pop) state_next = BS_IDLE;
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    item_take = (state == BS_IDLE) && item_valid;
    sq_start  = (state == BS_EXEC) && (uop.kind == UK_ROOT);
    res_load  = (state == BS_DONE) && (!res_valid || pop);
    vw_en     = (state == BS_EXEC) &&
                (((uop.kind == UK_NORM) && need_shift) ||
                 ((uop.kind == UK_CROSS) && !first));
    vw_id     = (uop.kind == UK_NORM) ? uop.x : uop.vd;
    vw_val    = (uop.kind == UK_NORM) ? nvec : dnew;
    unique case (rd_cnt[1:0])
      2'd0:    rd_addr = cur.a[BEAD_AW-1:0];
      2'd1:    rd_addr = cur.b[BEAD_AW-1:0];
      2'd2:    rd_addr = cur.c[BEAD_AW-1:0];
      default: rd_addr = cur.d[BEAD_AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      res_valid <= 1'b0;
      cut_len   <= RST_BOND_CUT;
      a_helix   <= RST_ANGLE_HELIX;
      a_coil    <= RST_ANGLE_COIL;
      d_helix   <= RST_DIHED_HELIX;
    end else begin
      state <= state_next;
      if (res_load) res_valid <= 1'b1;
      else if (pop) res_valid <= 1'b0;
      if (wr_en) begin
        unique case (wr_index)
          CFG_BOND_CUT:    cut_len <= wr_data[CUT_W-1:0];
          CFG_ANGLE_HELIX: a_helix <= wr_data;
          CFG_ANGLE_COIL:  a_coil  <= wr_data;
          default:         d_helix <= wr_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take && (item.op == OP_STORE)) begin
      mem[item.a[BEAD_AW-1:0]] <= {item.pz, item.py, item.px};
    end
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (res_load) res_code <= code;
    if (vw_en) begin
      unique case (vw_id)
        VI_U:    vec_u <= vw_val;
        VI_V:    vec_v <= vw_val;
        VI_W:    vec_w <= vw_val;
        VI_P:    vec_p <= vw_val;
        default: vec_q <= vw_val;
      endcase
    end
    unique case (state)
      BS_IDLE: begin
        if (item_take) begin
          cur    <= item;
          rd_cnt <= '0;
          code   <= CL_STORED;
        end
      end
      BS_READ: begin
        case (rd_cnt)
          3'd1:    pa <= mem_q;
          3'd2:    pb <= mem_q;
          3'd3:    pc <= mem_q;
          3'd4:    pd <= mem_q;
          default: ;
        endcase
        rd_cnt <= rd_cnt + 3'd1;
      end
      BS_DIFF: begin
        vec_u <= vdiff(pa, pb);
        vec_v <= (cur.op == OP_ANGLE) ? vdiff(pc, pb) : vdiff(pb, pc);
        vec_w <= vdiff(pd, pc);
        stp   <= '0;
        k     <= '0;
      end
      BS_EXEC: begin
        if (uop.kind == UK_DOT) begin
          acc <= acc_dot;
          if (k == 3'd2) begin
            case (uop.dd)
              DD_XX:   xx <= acc_dot[31:0];
              DD_YY:   yy <= acc_dot[31:0];
              DD_XY:   xy <= acc_dot[COMP_W-1:0];
              default: ;
            endcase
          end
        end else if ((uop.kind == UK_CROSS) && first) begin
          acc <= prod;
        end
        if (adv) begin
          stp <= stp + 4'd1;
          k   <= '0;
        end else if ((uop.kind == UK_DOT) || (uop.kind == UK_CROSS)) begin
          k <= k + 3'd1;
        end
        if (fin) code <= fin_code;
      end
      BS_SQRT: begin
        if (sq_done) begin
          root <= sq_root;
          stp  <= stp + 4'd1;
          k    <= '0;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== sv/bond_angle_dihedral_classifier_unit.sv =====
// Top level of the bead geometry classifier: input queue, sequencer and result word.
`default_nettype none
// The block keeps 4096 bead positions (signed Q12.20 x, y, z) and classifies
// bonds, angles and dihedrals over them, one result word per input word. A
// store word writes a bead and answers 7. Items run one at a time through a
// micro-coded sequencer with a single multiplier, a bead memory read one
// bead per cycle, and an iterative square root that yields one bit per
// cycle. A bond ends early when one component alone reaches the cutoff; an
// angle ends early for a zero-length arm, else halves each arm as often as
// needed to bring it to 15 bits and may fall through to the coil test; a
// dihedral, which halves each of its five vectors likewise, ends early on a
// flat plane or a negative sine. A result that is not popped holds the next
// one, and the sequencer, in its done state.
// A two-word input queue keeps taking words while the sequencer works, and a
// finished result waits in an output register, so push may proceed while the
// last result has not been popped. Configuration writes are taken at once and
// must only happen while the block is idle. Reading a bead that was never
// stored gives an undefined class.
module bond_angle_dihedral_classifier_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         operation,
  input  logic [11:0]        bead_a,
  input  logic [11:0]        bead_b,
  input  logic [11:0]        bead_c,
  input  logic [11:0]        bead_d,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         class_code,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [31:0]        wr_data
);
  import badc_pkg::*;

  // Items travel from the front queue to the sequencer as one struct word.
  item_t item;
  logic  item_valid;
  logic  item_take;

  badc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .bead_a     (bead_a),
    .bead_b     (bead_b),
    .bead_c     (bead_c),
    .bead_d     (bead_d),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // The back end owns the bead memory, so stores and classifies stay in order.
  badc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .pop        (pop),
    .empty      (empty),
    .class_code (class_code)
  );
endmodule
`default_nettype wire

// ===== sv/badc_checker.sv =====
// Port-level checker of the classifier and its bind to the top level.
`default_nettype none
`include "bond_angle_dihedral_classifier_unit_assert.svh"
module badc_assert_checker (
  input logic       clk,
  input logic       rst,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [2:0] class_code
);
  // Reset leaves no result and room for input.
  `BADC_ASSERT_RESET(a_reset_clear, rst, empty && !full)
  // A waiting result word holds until it is popped.
  `BADC_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(class_code))
  // The queue only fills through a push.
  `BADC_ASSERT_NEXT(a_full_needs_push, !full && !push, !full)
  // No result can appear in the first cycles after reset.
  `BADC_ASSERT_NEXT(a_no_early_result, $past(rst), empty)
endmodule

bind bond_angle_dihedral_classifier_unit badc_assert_checker u_chk (.*);
`default_nettype wire
